// ===== rtl/first_match_packet_filter_core_defines.svh =====
// ============================================================================
// Assertion macros for the packet filter core
// Shared concurrent assertion forms used by the checker.
// ============================================================================
`ifndef FIRST_MATCH_PACKET_FILTER_CORE_DEFINES_SVH
`define FIRST_MATCH_PACKET_FILTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMPF_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("packet filter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FMPF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("packet filter assertion failed");

`endif

// ===== rtl/fmpf_pkg.sv =====
// ============================================================================
// Packet filter package
// Command codes, controller states and the rule entry layout.
// ============================================================================
package fmpf_pkg;

   typedef enum logic [2:0] {
      CMD_CHECK   = 3'd0,
      CMD_ADD     = 3'd1,
      CMD_REMOVE  = 3'd2,
      CMD_ENABLE  = 3'd3,
      CMD_DISABLE = 3'd4,
      CMD_CLEAR   = 3'd5,
      CMD_STATS   = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REMOVE,
      ST_FLAG
   } state_type;

   localparam logic [1:0] DIR_BOTH = 2'd2;
   localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] sa_mask;
      logic [31:0] dst_addr;
      logic [31:0] da_mask;
      logic [15:0] sp_num;
      logic [15:0] dp_num;
      logic        enabled;
      logic [1:0]  action;
      logic [1:0]  dir;
      logic [7:0]  proto;
      logic [31:0] hits;
   } entry_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == SAT_MAX) ? v : v + 32'd1;
   endfunction

endpackage

// ===== rtl/first_match_packet_filter_core.sv =====
// ============================================================================
// First-match five-tuple packet filter core
// Ordered rule table in one simple dual-port synchronous memory, walked one rule
// per cycle for checks and shifted one entry per cycle for removals.
// ============================================================================
// Add, clear, stats reset, errors, removal of the last rule and checks with
// filtering off or no rules answer in the cycle after the item is accepted.
// A check walks the rules in order and answers on the first hit, or after the
// last rule if none hits. Remove of an earlier slot shifts later rules down;
// enable or disable rewrites the flag of that rule. One item at a time; the
// receiver cannot stall. Reset zeroes the counters and enables filtering.
module first_match_packet_filter_core #(
   parameter int RULE_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_src_addr_mask,
   input  logic [31:0] req_dst_addr,
   input  logic [31:0] req_dst_addr_mask,
   input  logic [15:0] req_src_port_num,
   input  logic [15:0] req_dst_port_num,
   input  logic [7:0]  req_proto_num,
   input  logic [1:0]  req_flow_dir,
   input  logic [1:0]  req_rule_action,
   input  logic [5:0]  req_rule_slot,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [1:0]  rsp_verdict,
   output logic        rsp_matched,
   output logic [5:0]  rsp_slot_out,
   output logic [6:0]  rsp_rules_in_use,
   output logic [31:0] rsp_hits_of_match,
   output logic [31:0] rsp_passed_total,
   output logic [31:0] rsp_blocked_total,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import fmpf_pkg::*;

   localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int CNT_W = $clog2(RULE_SLOTS + 1);
   localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

   entry_type mem [RULE_SLOTS];
   entry_type rd_data_ff;
   logic      wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type wr_data;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] ev_idx_ff, ev_idx_in;
   logic ev_valid_ff, ev_valid_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0] allowed_ff, allowed_in;
   logic [31:0] denied_ff, denied_in;
   logic enable_ff;

   logic [31:0] pkt_sa_ff, pkt_da_ff;
   logic [15:0] pkt_sp_ff, pkt_dp_ff;
   logic [7:0]  pkt_pr_ff;
   logic [1:0]  pkt_dir_ff;
   logic        flag_set_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_status_ff, rsp_status_in;
   logic [1:0] rsp_verdict_ff, rsp_verdict_in;
   logic rsp_matched_ff, rsp_matched_in;
   logic [5:0] rsp_slot_ff, rsp_slot_in;
   logic [31:0] rsp_hits_ff, rsp_hits_in;

   logic accept;
   logic hit;
   logic [CMP_W-1:0] slot_ext, count_ext;
   logic [CNT_W-1:0] last_idx;
   logic [1:0] verdict_sel;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign slot_ext  = CMP_W'(req_rule_slot);
   assign count_ext = CMP_W'(count_ff);
   assign last_idx  = count_ff - CNT_W'(1);

   assign hit = rd_data_ff.enabled
      && (rd_data_ff.dir == DIR_BOTH || rd_data_ff.dir == pkt_dir_ff)
      && (rd_data_ff.proto == 8'd0 || rd_data_ff.proto == pkt_pr_ff)
      && (rd_data_ff.sa_mask == 32'd0
          || (pkt_sa_ff & rd_data_ff.sa_mask) == (rd_data_ff.src_addr & rd_data_ff.sa_mask))
      && (rd_data_ff.da_mask == 32'd0
          || (pkt_da_ff & rd_data_ff.da_mask) == (rd_data_ff.dst_addr & rd_data_ff.da_mask))
      && (rd_data_ff.sp_num == 16'd0 || rd_data_ff.sp_num == pkt_sp_ff)
      && (rd_data_ff.dp_num == 16'd0 || rd_data_ff.dp_num == pkt_dp_ff);

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_idx_ff[IDX_W-1:0]];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      state_in       = state_ff;
      rd_idx_in      = rd_idx_ff + CNT_W'(1);
      ev_idx_in      = rd_idx_ff;
      ev_valid_in    = (rd_idx_ff < count_ff);
      count_in       = count_ff;
      allowed_in     = allowed_ff;
      denied_in      = denied_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = 1'b0;
      rsp_verdict_in = 2'd0;
      rsp_matched_in = 1'b0;
      rsp_slot_in    = 6'd0;
      rsp_hits_in    = 32'd0;
      wr_en          = 1'b0;
      wr_addr        = ev_idx_ff[IDX_W-1:0];
      wr_data        = rd_data_ff;
      verdict_sel    = 2'd0;
      unique case (state_ff)
         ST_IDLE: begin
            ev_valid_in = 1'b0;
            rd_idx_in   = rd_idx_ff;
            if (accept) begin
               rsp_valid_in = 1'b1;
               case (req_cmd)
                  CMD_CHECK: begin
                     if (enable_ff && count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        rd_idx_in    = '0;
                        state_in     = ST_CHECK;
                     end else begin
                        allowed_in = sat_inc(allowed_ff);
                     end
                  end
                  CMD_ADD: begin
                     if (count_ff == CNT_W'(RULE_SLOTS)) begin
                        rsp_status_in = 1'b1;
                     end else begin
                        wr_en            = 1'b1;
                        wr_addr          = count_ff[IDX_W-1:0];
                        wr_data.src_addr = req_src_addr;
                        wr_data.sa_mask  = req_src_addr_mask;
                        wr_data.dst_addr = req_dst_addr;
                        wr_data.da_mask  = req_dst_addr_mask;
                        wr_data.sp_num   = req_src_port_num;
                        wr_data.dp_num   = req_dst_port_num;
                        wr_data.enabled  = 1'b1;
                        wr_data.action   = req_rule_action;
                        wr_data.dir      = req_flow_dir;
                        wr_data.proto    = req_proto_num;
                        wr_data.hits     = 32'd0;
                        rsp_slot_in      = 6'(count_ff);
                        count_in         = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     if (slot_ext >= count_ext) begin
                        rsp_status_in = 1'b1;
                     end else if (slot_ext == CMP_W'(last_idx)) begin
                        count_in = last_idx;
                     end else begin
                        rsp_valid_in = 1'b0;
                        rd_idx_in    = CNT_W'(slot_ext) + CNT_W'(1);
                        state_in     = ST_REMOVE;
                     end
                  end
                  CMD_ENABLE, CMD_DISABLE: begin
                     if (slot_ext >= count_ext) begin
                        rsp_status_in = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b0;
                        rd_idx_in    = CNT_W'(slot_ext);
                        state_in     = ST_FLAG;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  CMD_STATS: begin
                     allowed_in = 32'd0;
                     denied_in  = 32'd0;
                  end
                  default: begin
                     rsp_status_in = 1'b1;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (ev_valid_ff && (hit || ev_idx_ff == last_idx)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (hit) begin
                  verdict_sel    = rd_data_ff.action;
                  wr_en          = 1'b1;
                  wr_data.hits   = sat_inc(rd_data_ff.hits);
                  rsp_matched_in = 1'b1;
                  rsp_slot_in    = 6'(ev_idx_ff);
                  rsp_hits_in    = sat_inc(rd_data_ff.hits);
                  rsp_verdict_in = rd_data_ff.action;
               end
               if (verdict_sel == 2'd0) begin
                  allowed_in = sat_inc(allowed_ff);
               end else begin
                  denied_in = sat_inc(denied_ff);
               end
            end
         end
         ST_REMOVE: begin
            if (ev_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = ev_idx_ff[IDX_W-1:0] - IDX_W'(1);
               if (ev_idx_ff == last_idx) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  count_in     = last_idx;
               end
            end
         end
         ST_FLAG: begin
            if (ev_valid_ff) begin
               wr_en           = 1'b1;
               wr_data.enabled = flag_set_ff;
               state_in        = ST_IDLE;
               rsp_valid_in    = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= '0;
         ev_idx_ff    <= '0;
         ev_valid_ff  <= 1'b0;
         count_ff     <= '0;
         allowed_ff   <= 32'd0;
         denied_ff    <= 32'd0;
         enable_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         ev_idx_ff    <= ev_idx_in;
         ev_valid_ff  <= ev_valid_in;
         count_ff     <= count_in;
         allowed_ff   <= allowed_in;
         denied_ff    <= denied_in;
         rsp_valid_ff <= rsp_valid_in;
         if (psel && penable && pwrite && paddr == 3'd0) begin
            enable_ff <= pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pkt_sa_ff   <= req_src_addr;
         pkt_da_ff   <= req_dst_addr;
         pkt_sp_ff   <= req_src_port_num;
         pkt_dp_ff   <= req_dst_port_num;
         pkt_pr_ff   <= req_proto_num;
         pkt_dir_ff  <= req_flow_dir;
         flag_set_ff <= (req_cmd == CMD_ENABLE);
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_hits_ff    <= rsp_hits_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_verdict       = rsp_verdict_ff;
   assign rsp_matched       = rsp_matched_ff;
   assign rsp_slot_out      = rsp_slot_ff;
   assign rsp_rules_in_use  = 7'(count_ff);
   assign rsp_hits_of_match = rsp_hits_ff;
   assign rsp_passed_total  = allowed_ff;
   assign rsp_blocked_total = denied_ff;
   assign prdata            = (paddr == 3'd0) ? {31'd0, enable_ff} : 32'd0;
   assign pready            = 1'b1;

endmodule

// ===== rtl/fmpf_checker.sv =====
// ============================================================================
// Packet filter port checker
// Watches the top level ports for result and busy consistency.
// ============================================================================
`include "first_match_packet_filter_core_defines.svh"

module fmpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_cmd,
   input logic        rsp_valid,
   input logic        rsp_status,
   input logic [1:0]  rsp_verdict,
   input logic        rsp_matched,
   input logic [6:0]  rsp_rules_in_use,
   input logic [31:0] rsp_hits_of_match
);
   import fmpf_pkg::*;

   `FMPF_ASSERT_SAME(a_no_rsp_busy, busy, !rsp_valid)
   `FMPF_ASSERT_SAME(a_nomatch_clean, rsp_valid && !rsp_matched,
      rsp_verdict == 2'd0 && rsp_hits_of_match == 32'd0)
   `FMPF_ASSERT_SAME(a_err_nomatch, rsp_valid && rsp_status, !rsp_matched)
   `FMPF_ASSERT_NEXT(a_clear_empty, start && !busy && req_cmd == CMD_CLEAR,
      rsp_valid && rsp_rules_in_use == 7'd0)

endmodule

bind first_match_packet_filter_core fmpf_checker u_fmpf_checker (.*);

// ===== verif/first_match_packet_filter_core_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Packet filter result checker
// Watches accepted command items and result strobes, keeps its own copy of
// the rule table and counters, and compares every result field by field.
// ============================================================================
module first_match_packet_filter_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_src_addr_mask,
   input  logic [31:0] req_dst_addr,
   input  logic [31:0] req_dst_addr_mask,
   input  logic [15:0] req_src_port_num,
   input  logic [15:0] req_dst_port_num,
   input  logic [7:0]  req_proto_num,
   input  logic [1:0]  req_flow_dir,
   input  logic [1:0]  req_rule_action,
   input  logic [5:0]  req_rule_slot,
   input  logic        rsp_valid,
   input  logic        rsp_status,
   input  logic [1:0]  rsp_verdict,
   input  logic        rsp_matched,
   input  logic [5:0]  rsp_slot_out,
   input  logic [6:0]  rsp_rules_in_use,
   input  logic [31:0] rsp_hits_of_match,
   input  logic [31:0] rsp_passed_total,
   input  logic [31:0] rsp_blocked_total,
   input  logic        filter_on,
   output int          failures,
   output int          pending,
   output int          results_seen
);
   import fmpf_pkg::*;

   localparam int SLOTS = 64;

   typedef struct packed {
      logic        status;
      logic [1:0]  verdict;
      logic        matched;
      logic [5:0]  slot_out;
      logic [6:0]  rules_in_use;
      logic [31:0] hits;
      logic [31:0] passed;
      logic [31:0] blocked;
   } outcome_type;

   entry_type   rules [SLOTS];
   int          held_rules;
   logic [31:0] passed_count;
   logic [31:0] blocked_count;
   outcome_type awaited [$];

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic rule_hits(input entry_type r, input logic [1:0] dir,
                                      input logic [7:0] pr, input logic [31:0] sa,
                                      input logic [31:0] da, input logic [15:0] sp,
                                      input logic [15:0] dp);
      return r.enabled && (r.dir == DIR_BOTH || r.dir == dir)
         && (r.proto == 8'd0 || r.proto == pr)
         && (r.sa_mask == 0 || ((sa ^ r.src_addr) & r.sa_mask) == 0)
         && (r.da_mask == 0 || ((da ^ r.dst_addr) & r.da_mask) == 0)
         && (r.sp_num == 16'd0 || r.sp_num == sp)
         && (r.dp_num == 16'd0 || r.dp_num == dp);
   endfunction

   task automatic apply_command();
      outcome_type o;
      int          k;
      o = '0;
      case (req_cmd)
         CMD_CHECK: begin
            if (filter_on) begin
               for (k = 0; k < held_rules; k++) begin
                  if (rule_hits(rules[k], req_flow_dir, req_proto_num, req_src_addr,
                                req_dst_addr, req_src_port_num, req_dst_port_num)) begin
                     rules[k].hits = bump(rules[k].hits);
                     o.matched = 1'b1;
                     o.slot_out = k[5:0];
                     o.hits = rules[k].hits;
                     o.verdict = rules[k].action;
                     break;
                  end
               end
            end
            if (o.verdict == 2'd0) passed_count = bump(passed_count);
            else blocked_count = bump(blocked_count);
         end
         CMD_ADD: begin
            if (held_rules >= SLOTS) begin
               o.status = 1'b1;
            end else begin
               rules[held_rules] = '{src_addr: req_src_addr, sa_mask: req_src_addr_mask,
                  dst_addr: req_dst_addr, da_mask: req_dst_addr_mask,
                  sp_num: req_src_port_num, dp_num: req_dst_port_num,
                  enabled: 1'b1, action: req_rule_action, dir: req_flow_dir,
                  proto: req_proto_num, hits: 32'd0};
               o.slot_out = held_rules[5:0];
               held_rules++;
            end
         end
         CMD_REMOVE: begin
            if (req_rule_slot >= held_rules) begin
               o.status = 1'b1;
            end else begin
               for (k = req_rule_slot; k + 1 < held_rules; k++) rules[k] = rules[k + 1];
               held_rules--;
            end
         end
         CMD_ENABLE, CMD_DISABLE: begin
            if (req_rule_slot >= held_rules) o.status = 1'b1;
            else rules[req_rule_slot].enabled = (req_cmd == CMD_ENABLE);
         end
         CMD_CLEAR: held_rules = 0;
         CMD_STATS: begin
            passed_count = '0;
            blocked_count = '0;
         end
         default: o.status = 1'b1;
      endcase
      o.rules_in_use = held_rules[6:0];
      o.passed = passed_count;
      o.blocked = blocked_count;
      awaited.push_back(o);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         held_rules = 0;
         passed_count = '0;
         blocked_count = '0;
         awaited.delete();
         failures = failures;
      end else begin
         if (rsp_valid) begin
            results_seen++;
            if (awaited.size() == 0) begin
               $error("Result arrived with no item outstanding.");
               failures++;
            end else begin
               e = awaited.pop_front();
               compare_field("status", e.status, rsp_status);
               compare_field("verdict", e.verdict, rsp_verdict);
               compare_field("matched", e.matched, rsp_matched);
               compare_field("slot_out", e.slot_out, rsp_slot_out);
               compare_field("rules_in_use", e.rules_in_use, rsp_rules_in_use);
               compare_field("hits_of_match", e.hits, rsp_hits_of_match);
               compare_field("passed_total", e.passed, rsp_passed_total);
               compare_field("blocked_total", e.blocked, rsp_blocked_total);
            end
         end
         if (start && !busy) apply_command();
      end
      pending = awaited.size();
   end

   initial begin
      failures = 0;
      pending = 0;
      results_seen = 0;
   end

endmodule

// ===== verif/first_match_packet_filter_core_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Packet filter core testbench
// Drives directed and random rule table commands and filter enable writes,
// while a separate checker predicts and compares every result.
// ============================================================================
module first_match_packet_filter_core_tb;
   import fmpf_pkg::*;

   localparam logic [2:0] ADDR_FILTER_ENABLE = 3'd0;
   localparam logic [2:0] CMD_UNKNOWN = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_cmd = '0;
   logic [31:0] req_src_addr = '0, req_src_addr_mask = '0;
   logic [31:0] req_dst_addr = '0, req_dst_addr_mask = '0;
   logic [15:0] req_src_port_num = '0, req_dst_port_num = '0;
   logic [7:0]  req_proto_num = '0;
   logic [1:0]  req_flow_dir = '0, req_rule_action = '0;
   logic [5:0]  req_rule_slot = '0;
   logic        rsp_valid, rsp_status, rsp_matched;
   logic [1:0]  rsp_verdict;
   logic [5:0]  rsp_slot_out;
   logic [6:0]  rsp_rules_in_use;
   logic [31:0] rsp_hits_of_match, rsp_passed_total, rsp_blocked_total;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   logic        filter_on = 1'b1;
   int          failures, pending, results_seen;
   int          items_sent = 0;
   logic [31:0] pool_addr [8];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   first_match_packet_filter_core dut (.*);

   first_match_packet_filter_core_checker checker_inst (.*);

   task automatic send_item(input logic [2:0] cmd, input logic [31:0] sa,
                            input logic [31:0] sm, input logic [31:0] da,
                            input logic [31:0] dm, input logic [15:0] sp,
                            input logic [15:0] dp, input logic [7:0] pr,
                            input logic [1:0] dir, input logic [1:0] act,
                            input logic [5:0] slot, input bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) @(negedge clock);
      req_cmd = cmd;
      req_src_addr = sa;
      req_src_addr_mask = sm;
      req_dst_addr = da;
      req_dst_addr_mask = dm;
      req_src_port_num = sp;
      req_dst_port_num = dp;
      req_proto_num = pr;
      req_flow_dir = dir;
      req_rule_action = act;
      req_rule_slot = slot;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 1'b0;
      items_sent++;
   endtask

   task automatic settle();
      while (pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_filter_enable(input logic value);
      settle();
      psel = 1'b1;
      pwrite = 1'b1;
      paddr = ADDR_FILTER_ENABLE;
      pwdata = {$urandom} & 32'hFFFF_FFFE | value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      filter_on = value;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // Rules drawn from a small address pool so that later checks hit them.
   task automatic random_add(input bit gaps);
      logic [31:0] sm, dm;
      sm = ($urandom_range(0, 2) == 0) ? 32'd0 : ~32'd0 << $urandom_range(0, 31);
      dm = ($urandom_range(0, 2) == 0) ? 32'd0 : ~32'd0 << $urandom_range(0, 31);
      send_item(CMD_ADD, pool_addr[$urandom_range(0, 7)], sm,
                pool_addr[$urandom_range(0, 7)], dm,
                $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 3)),
                $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 3)),
                $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 2)),
                2'($urandom_range(0, 3)), 2'($urandom), 6'($urandom), gaps);
   endtask

   task automatic random_check(input bit gaps);
      bit wild;
      wild = ($urandom_range(0, 9) == 0);
      send_item(CMD_CHECK,
                wild ? $urandom : pool_addr[$urandom_range(0, 7)] ^ ($urandom & 32'h0F),
                $urandom,
                wild ? $urandom : pool_addr[$urandom_range(0, 7)] ^ ($urandom & 32'h0F),
                $urandom,
                wild ? 16'($urandom) : 16'($urandom_range(0, 3)),
                wild ? 16'($urandom) : 16'($urandom_range(0, 3)),
                wild ? 8'($urandom) : 8'($urandom_range(0, 2)),
                2'($urandom_range(0, 3)), 2'($urandom), 6'($urandom), gaps);
   endtask

   task automatic random_other(input bit gaps);
      int pick;
      logic [2:0] cmd;
      pick = $urandom_range(0, 19);
      if (pick < 6) cmd = CMD_REMOVE;
      else if (pick < 11) cmd = CMD_DISABLE;
      else if (pick < 15) cmd = CMD_ENABLE;
      else if (pick < 17) cmd = CMD_STATS;
      else if (pick < 18) cmd = CMD_CLEAR;
      else cmd = CMD_UNKNOWN;
      send_item(cmd, $urandom, $urandom, $urandom, $urandom, 16'($urandom),
                16'($urandom), 8'($urandom), 2'($urandom), 2'($urandom),
                ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15)),
                gaps);
   endtask

   initial begin
      #400000000;
      $display("first_match_packet_filter_core: mismatch");
      $finish;
   end

   initial begin
      int n;
      for (n = 0; n < 8; n++) pool_addr[n] = $urandom;
      pool_addr[0] = 32'd0;
      pool_addr[1] = 32'hFFFF_FFFF;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: extremes, every command and the error cases.
      send_item(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 6'd0, 0);
      send_item(CMD_ENABLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 6'd63, 0);
      send_item(CMD_CHECK, '1, '1, '1, '1, '1, '1, '1, 2'd3, 2'd3, '1, 0);
      send_item(CMD_ADD, '1, '1, '1, '1, '1, '1, '1, 2'd3, 2'd3, '1, 0);
      send_item(CMD_ADD, 0, 0, 0, 0, 0, 0, 0, DIR_BOTH, 2'd2, 0, 0);
      send_item(CMD_ADD, 32'hC0A8_0000, 32'hFFFF_0000, 0, 0, 16'd80, 0, 8'd6, 2'd0,
                2'd1, 0, 0);
      send_item(CMD_CHECK, '1, 0, '1, 0, '1, '1, '1, 2'd3, 0, 0, 0);
      send_item(CMD_CHECK, 32'h1234_5678, 0, 0, 0, 16'd1, 16'd2, 8'd17, 2'd1, 0, 0, 0);
      send_item(CMD_CHECK, 0, 0, 0, 0, 0, 0, 0, DIR_BOTH, 0, 0, 0);
      send_item(CMD_DISABLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 6'd1, 0);
      send_item(CMD_CHECK, 32'hC0A8_1111, 0, 0, 0, 16'd80, 0, 8'd6, 2'd0, 0, 0, 0);
      send_item(CMD_ENABLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 6'd1, 0);
      send_item(CMD_CHECK, 32'hC0A8_2222, 0, 0, 0, 16'd80, 0, 8'd6, 2'd0, 0, 0, 0);
      send_item(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 6'd0, 0);
      send_item(CMD_CHECK, 32'hC0A8_2222, 0, 0, 0, 16'd80, 0, 8'd6, 2'd0, 0, 0, 0);
      send_item(CMD_UNKNOWN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_item(CMD_STATS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      write_filter_enable(1'b0);
      send_item(CMD_CHECK, 32'hC0A8_2222, 0, 0, 0, 16'd80, 0, 8'd6, 2'd0, 0, 0, 0);
      write_filter_enable(1'b1);
      // Fill the table to hit the full case, then remove the last slot.
      for (n = 0; n < 66; n++) random_add(0);
      send_item(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 6'd63, 0);
      send_item(CMD_CHECK, 0, 0, 0, 0, 0, 0, 0, 2'd1, 0, 0, 0);
      send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

      // Random phases with different filter settings.
      for (n = 0; n < 1700; n++) begin
         if (n % 400 == 399) write_filter_enable($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2: random_add(n < 1500);
            3, 4, 5, 6, 7: random_check(n < 1500);
            default: random_other(n < 1500);
         endcase
      end

      settle();
      $display("Sent %0d command items, checked %0d results, with filtering on and off.",
               items_sent, results_seen);
      if (failures == 0) begin
         $display("first_match_packet_filter_core: match");
      end else begin
         $display("first_match_packet_filter_core: mismatch");
      end
      $finish;
   end

endmodule
